>>> rtl/ptcb_pkg.sv
package ptcb_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int LIMIT_WIDTH = 63;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 63'd18446744074;

endpackage

>>> rtl/ptcb_front.sv
module ptcb_front #(
    parameter int CW = ptcb_pkg::COORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [CW-1:0]  i_a [3],
    input  logic signed [CW-1:0]  i_b [3],
    input  logic signed [CW-1:0]  i_c [3],
    input  logic signed [CW-1:0]  i_q [3],
    output logic                  o_valid,
    output logic signed [2*CW+3:0] o_saa,
    output logic signed [2*CW+3:0] o_sab,
    output logic signed [2*CW+3:0] o_sbb,
    output logic signed [2*CW+3:0] o_da,
    output logic signed [2*CW+3:0] o_db,
    output logic signed [CW:0]    o_ea [3],
    output logic signed [CW:0]    o_eb [3],
    output logic signed [CW-1:0]  o_c [3]
);

    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int DW = PW + 2;

    logic signed [EW-1:0] r1_ea [3];
    logic signed [EW-1:0] r1_eb [3];
    logic signed [EW-1:0] r1_eq [3];
    logic signed [CW-1:0] r1_c [3];
    logic                 r1_v;

    logic signed [PW-1:0] r2_aa [3];
    logic signed [PW-1:0] r2_ab [3];
    logic signed [PW-1:0] r2_bb [3];
    logic signed [PW-1:0] r2_aq [3];
    logic signed [PW-1:0] r2_bq [3];
    logic signed [EW-1:0] r2_ea [3];
    logic signed [EW-1:0] r2_eb [3];
    logic signed [CW-1:0] r2_c [3];
    logic                 r2_v;

    logic signed [DW-1:0] r3_saa, r3_sab, r3_sbb, r3_da, r3_db;
    logic signed [EW-1:0] r3_ea [3];
    logic signed [EW-1:0] r3_eb [3];
    logic signed [CW-1:0] r3_c [3];
    logic                 r3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_ea[k] <= EW'(i_a[k]) - EW'(i_c[k]);
                r1_eb[k] <= EW'(i_b[k]) - EW'(i_c[k]);
                r1_eq[k] <= EW'(i_q[k]) - EW'(i_c[k]);
                r1_c[k]  <= i_c[k];

                r2_aa[k] <= r1_ea[k] * r1_ea[k];
                r2_ab[k] <= r1_ea[k] * r1_eb[k];
                r2_bb[k] <= r1_eb[k] * r1_eb[k];
                r2_aq[k] <= r1_ea[k] * r1_eq[k];
                r2_bq[k] <= r1_eb[k] * r1_eq[k];
                r2_ea[k] <= r1_ea[k];
                r2_eb[k] <= r1_eb[k];
                r2_c[k]  <= r1_c[k];

                r3_ea[k] <= r2_ea[k];
                r3_eb[k] <= r2_eb[k];
                r3_c[k]  <= r2_c[k];
            end
            r3_saa <= DW'(r2_aa[0]) + DW'(r2_aa[1]) + DW'(r2_aa[2]);
            r3_sab <= DW'(r2_ab[0]) + DW'(r2_ab[1]) + DW'(r2_ab[2]);
            r3_sbb <= DW'(r2_bb[0]) + DW'(r2_bb[1]) + DW'(r2_bb[2]);
            r3_da  <= DW'(r2_aq[0]) + DW'(r2_aq[1]) + DW'(r2_aq[2]);
            r3_db  <= DW'(r2_bq[0]) + DW'(r2_bq[1]) + DW'(r2_bq[2]);
        end
    end

    assign o_valid = r3_v;
    assign o_saa   = r3_saa;
    assign o_sab   = r3_sab;
    assign o_sbb   = r3_sbb;
    assign o_da    = r3_da;
    assign o_db    = r3_db;
    assign o_ea    = r3_ea;
    assign o_eb    = r3_eb;
    assign o_c     = r3_c;

endmodule

>>> rtl/ptcb_mul.sv
module ptcb_mul #(
    parameter int W  = 53,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic signed [2*W-1:0] o_p,
    output logic [SW-1:0]         o_side
);

    localparam int H  = (W + 1) / 2;
    localparam int G  = W - H;
    localparam int PW = 2 * W;

    logic [W-1:0]     r1_ma, r1_mb;
    logic             r1_neg, r1_v;
    logic [SW-1:0]    r1_side;

    logic [2*H-1:0]   r2_ll;
    logic [H+G-1:0]   r2_lh, r2_hl;
    logic [2*G-1:0]   r2_hh;
    logic             r2_neg, r2_v;
    logic [SW-1:0]    r2_side;

    logic signed [PW-1:0] r3_p;
    logic             r3_v;
    logic [SW-1:0]    r3_side;

    logic [PW-1:0]    n3_sum;

    always_comb begin
        n3_sum = (PW'(r2_hh) << (2 * H))
               + ((PW'(r2_lh) + PW'(r2_hl)) << H)
               + PW'(r2_ll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ma   <= i_a[W-1] ? W'(-i_a) : W'(i_a);
            r1_mb   <= i_b[W-1] ? W'(-i_b) : W'(i_b);
            r1_neg  <= i_a[W-1] ^ i_b[W-1];
            r1_side <= i_side;

            r2_ll   <= r1_ma[H-1:0] * r1_mb[H-1:0];
            r2_lh   <= r1_ma[H-1:0] * r1_mb[W-1:H];
            r2_hl   <= r1_ma[W-1:H] * r1_mb[H-1:0];
            r2_hh   <= r1_ma[W-1:H] * r1_mb[W-1:H];
            r2_neg  <= r1_neg;
            r2_side <= r1_side;

            r3_p    <= r2_neg ? -$signed(n3_sum) : $signed(n3_sum);
            r3_side <= r2_side;
        end
    end

    assign o_valid = r3_v;
    assign o_p     = r3_p;
    assign o_side  = r3_side;

endmodule

>>> rtl/ptcb_div.sv
module ptcb_div #(
    parameter int XW = 124,
    parameter int YW = 107,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [XW-1:0] i_x,
    input  logic [YW-1:0] i_y,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_q,
    output logic [SW-1:0] o_side
);

    logic [XW-1:0] r_rem  [QW];
    logic [YW-1:0] r_y    [QW];
    logic [QW-1:0] r_q    [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_v;

    logic [XW-1:0] n_rem  [QW];
    logic [YW-1:0] w_y    [QW];
    logic [QW-1:0] n_q    [QW];
    logic [SW-1:0] w_side [QW];

    always_comb begin
        logic [XW-1:0] v_rem;
        logic [XW-1:0] v_dsh;
        logic [QW-1:0] v_q;
        logic          v_bit;
        for (int j = 0; j < QW; j++) begin
            if (j == 0) begin
                v_rem     = i_x;
                w_y[j]    = i_y;
                v_q       = '0;
                w_side[j] = i_side;
            end else begin
                v_rem     = r_rem[j-1];
                w_y[j]    = r_y[j-1];
                v_q       = r_q[j-1];
                w_side[j] = r_side[j-1];
            end
            v_dsh    = XW'(w_y[j]) << (QW - 1 - j);
            v_bit    = v_rem >= v_dsh;
            n_rem[j] = v_bit ? v_rem - v_dsh : v_rem;
            n_q[j]   = v_q | (QW'(v_bit) << (QW - 1 - j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QW; j++) begin
                r_rem[j]  <= n_rem[j];
                r_y[j]    <= w_y[j];
                r_q[j]    <= n_q[j];
                r_side[j] <= w_side[j];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

>>> rtl/point_triangle_closest_bary.sv
// Closest point on a triangle by barycentric weights, fully pipelined.
//
// Input channel: i_valid / o_ready carry one word of three vertices and a
// query point. Output channel: o_valid / i_ready carry the flag o_found, the
// three weights and the near point. A word is moved when valid and ready are
// both high at a rising clock edge.
// The degenerate limit r_limit is written through i_cfg_we / i_cfg_data.
//
// Three stages for the dot products, three for each split wide multiplier,
// three for the determinant checks, FRAC_BITS+1 for each restoring weight
// divider, the clamped weights and rescaling products, FRAC_BITS+1 for each
// rescaling divider, then the rescaled weights, the near point and the output
// register. One word is taken every cycle unless the receiver stalls. Reset
// clears all valid bits and loads the default limit. When the receiver
// stalls with a word waiting, the whole pipeline holds; nothing is lost.
module point_triangle_closest_bary #(
    parameter int COORD_WIDTH = ptcb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ptcb_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ptcb_pkg::LIMIT_WIDTH-1:0] i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [COORD_WIDTH-1:0]    i_a_x,
    input  logic signed [COORD_WIDTH-1:0]    i_a_y,
    input  logic signed [COORD_WIDTH-1:0]    i_a_z,
    input  logic signed [COORD_WIDTH-1:0]    i_b_x,
    input  logic signed [COORD_WIDTH-1:0]    i_b_y,
    input  logic signed [COORD_WIDTH-1:0]    i_b_z,
    input  logic signed [COORD_WIDTH-1:0]    i_c_x,
    input  logic signed [COORD_WIDTH-1:0]    i_c_y,
    input  logic signed [COORD_WIDTH-1:0]    i_c_z,
    input  logic signed [COORD_WIDTH-1:0]    i_q_x,
    input  logic signed [COORD_WIDTH-1:0]    i_q_y,
    input  logic signed [COORD_WIDTH-1:0]    i_q_z,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_found,
    output logic [FRAC_BITS:0]               o_weight_a,
    output logic [FRAC_BITS:0]               o_weight_b,
    output logic [FRAC_BITS:0]               o_weight_c,
    output logic signed [COORD_WIDTH-1:0]    o_near_x,
    output logic signed [COORD_WIDTH-1:0]    o_near_y,
    output logic signed [COORD_WIDTH-1:0]    o_near_z
);

    localparam int CW   = COORD_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int LW   = ptcb_pkg::LIMIT_WIDTH;
    localparam int EW   = CW + 1;
    localparam int DW   = 2 * EW + 2;
    localparam int MW   = 2 * DW;
    localparam int GW   = MW + 1;
    localparam int WW   = FB + 1;
    localparam int CMPW = (GW > LW) ? GW : LW;
    localparam int XW1  = GW + FB + 1;
    localparam int XW2  = 2 * WW + 1;
    localparam int GS   = 3 * CW + 6 * EW;
    localparam int SW1  = GS + 3;
    localparam int SW2  = GS + 2 * WW + 3;
    localparam int JW   = WW + 1 + EW;
    localparam int NW   = JW + 1;
    localparam logic [WW-1:0] ONE = WW'(1) << FB;

    logic en;
    logic [LW-1:0] r_limit;

    logic signed [CW-1:0] w_a [3];
    logic signed [CW-1:0] w_b [3];
    logic signed [CW-1:0] w_c [3];
    logic signed [CW-1:0] w_q [3];

    logic                 f_v;
    logic signed [DW-1:0] f_saa, f_sab, f_sbb, f_da, f_db;
    logic signed [EW-1:0] f_ea [3];
    logic signed [EW-1:0] f_eb [3];
    logic signed [CW-1:0] f_c [3];
    logic [GS-1:0]        f_geom;

    logic                 m_v;
    logic signed [MW-1:0] m_p [6];
    logic [GS-1:0]        m_geom;

    logic signed [GW-1:0] r_d_det, r_d_na, r_d_nb;
    logic [GS-1:0]        r_d_geom;
    logic                 r_d_v;

    logic [GW-1:0]        r_e_ad, r_e_an, r_e_bn;
    logic                 r_e_za, r_e_zb, r_e_dz, r_e_v;
    logic [GS-1:0]        r_e_geom;

    logic [GW-1:0]        r_f_ad, r_f_an, r_f_bn;
    logic                 r_f_za, r_f_zb, r_f_ova, r_f_ovb, r_f_degen, r_f_v;
    logic [GS-1:0]        r_f_geom;

    logic                 d1_v;
    logic [WW-1:0]        d1_qa, d1_qb;
    logic [SW1-1:0]       d1_side;
    logic [1:0]           d1_bside;

    logic [WW-1:0]        n_g_wa, n_g_wb;
    logic [WW:0]          n_g_s;
    logic [WW-1:0]        r_g_wa, r_g_wb, r_g_e;
    logic [WW:0]          r_g_s;
    logic                 r_g_neg, r_g_degen, r_g_v;
    logic [GS-1:0]        r_g_geom;

    logic [2*WW-1:0]      r_h_xa, r_h_xb;
    logic [WW-1:0]        r_h_wa, r_h_wb;
    logic [WW:0]          r_h_s;
    logic                 r_h_neg, r_h_degen, r_h_v;
    logic [GS-1:0]        r_h_geom;

    logic                 d2_v;
    logic [WW-1:0]        d2_qa, d2_qb;
    logic [SW2-1:0]       d2_side;
    logic [WW-1:0]        d2_bside;

    logic [WW-1:0]        r_i_wa, r_i_wb, r_i_wc;
    logic                 r_i_degen, r_i_v;
    logic [GS-1:0]        r_i_geom;

    logic signed [CW-1:0] i_c [3];
    logic signed [EW-1:0] i_ea [3];
    logic signed [EW-1:0] i_eb [3];

    logic signed [JW-1:0] r_j_pa [3];
    logic signed [JW-1:0] r_j_pb [3];
    logic signed [CW-1:0] r_j_c [3];
    logic [WW-1:0]        r_j_wa, r_j_wb, r_j_wc;
    logic                 r_j_degen, r_j_v;

    logic signed [CW-1:0] n_near [3];

    logic                 r_o_valid, r_o_found;
    logic [WW-1:0]        r_o_wa, r_o_wb, r_o_wc;
    logic signed [CW-1:0] r_o_near [3];

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ptcb_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    assign w_a = '{i_a_x, i_a_y, i_a_z};
    assign w_b = '{i_b_x, i_b_y, i_b_z};
    assign w_c = '{i_c_x, i_c_y, i_c_z};
    assign w_q = '{i_q_x, i_q_y, i_q_z};

    ptcb_front #(.CW(CW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_a(w_a), .i_b(w_b), .i_c(w_c), .i_q(w_q),
        .o_valid(f_v), .o_saa(f_saa), .o_sab(f_sab), .o_sbb(f_sbb),
        .o_da(f_da), .o_db(f_db), .o_ea(f_ea), .o_eb(f_eb), .o_c(f_c)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            f_geom[k*CW +: CW]             = f_c[k];
            f_geom[3*CW + k*EW +: EW]      = f_ea[k];
            f_geom[3*CW + 3*EW + k*EW +: EW] = f_eb[k];
        end
    end

    ptcb_mul #(.W(DW), .SW(GS)) u_mul_det0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_v),
        .i_a(f_saa), .i_b(f_sbb), .i_side(f_geom),
        .o_valid(m_v), .o_p(m_p[0]), .o_side(m_geom)
    );
    ptcb_mul #(.W(DW), .SW(1)) u_mul_det1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_v),
        .i_a(f_sab), .i_b(f_sab), .i_side(1'b0),
        .o_valid(), .o_p(m_p[1]), .o_side()
    );
    ptcb_mul #(.W(DW), .SW(1)) u_mul_na0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_v),
        .i_a(f_sbb), .i_b(f_da), .i_side(1'b0),
        .o_valid(), .o_p(m_p[2]), .o_side()
    );
    ptcb_mul #(.W(DW), .SW(1)) u_mul_na1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_v),
        .i_a(f_sab), .i_b(f_db), .i_side(1'b0),
        .o_valid(), .o_p(m_p[3]), .o_side()
    );
    ptcb_mul #(.W(DW), .SW(1)) u_mul_nb0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_v),
        .i_a(f_saa), .i_b(f_db), .i_side(1'b0),
        .o_valid(), .o_p(m_p[4]), .o_side()
    );
    ptcb_mul #(.W(DW), .SW(1)) u_mul_nb1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_v),
        .i_a(f_sab), .i_b(f_da), .i_side(1'b0),
        .o_valid(), .o_p(m_p[5]), .o_side()
    );

    // Determinant, magnitudes and the degenerate and clamp checks.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_det  <= GW'(m_p[0]) - GW'(m_p[1]);
            r_d_na   <= GW'(m_p[2]) - GW'(m_p[3]);
            r_d_nb   <= GW'(m_p[4]) - GW'(m_p[5]);
            r_d_geom <= m_geom;

            r_e_ad   <= r_d_det[GW-1] ? GW'(-r_d_det) : GW'(r_d_det);
            r_e_an   <= r_d_na[GW-1] ? GW'(-r_d_na) : GW'(r_d_na);
            r_e_bn   <= r_d_nb[GW-1] ? GW'(-r_d_nb) : GW'(r_d_nb);
            r_e_za   <= (r_d_na == '0) || (r_d_na[GW-1] != r_d_det[GW-1]);
            r_e_zb   <= (r_d_nb == '0) || (r_d_nb[GW-1] != r_d_det[GW-1]);
            r_e_dz   <= r_d_det == '0;
            r_e_geom <= r_d_geom;

            r_f_ad    <= r_e_ad;
            r_f_an    <= r_e_an;
            r_f_bn    <= r_e_bn;
            r_f_za    <= r_e_za;
            r_f_zb    <= r_e_zb;
            r_f_ova   <= {1'b0, r_e_an} >= {r_e_ad, 1'b0};
            r_f_ovb   <= {1'b0, r_e_bn} >= {r_e_ad, 1'b0};
            r_f_degen <= r_e_dz || (CMPW'(r_e_ad) < CMPW'(r_limit));
            r_f_geom  <= r_e_geom;
        end
    end

    ptcb_div #(.XW(XW1), .YW(GW), .QW(WW), .SW(SW1)) u_div_wa (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_f_v),
        .i_x(XW1'(r_f_an) << FB), .i_y(r_f_ad),
        .i_side({r_f_geom, r_f_degen, r_f_za, r_f_ova}),
        .o_valid(d1_v), .o_q(d1_qa), .o_side(d1_side)
    );
    ptcb_div #(.XW(XW1), .YW(GW), .QW(WW), .SW(2)) u_div_wb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_f_v),
        .i_x(XW1'(r_f_bn) << FB), .i_y(r_f_ad),
        .i_side({r_f_zb, r_f_ovb}),
        .o_valid(), .o_q(d1_qb), .o_side(d1_bside)
    );

    always_comb begin
        if (d1_side[1]) begin
            n_g_wa = '0;
        end else if (d1_side[0] || (d1_qa > ONE)) begin
            n_g_wa = ONE;
        end else begin
            n_g_wa = d1_qa;
        end
        if (d1_bside[1]) begin
            n_g_wb = '0;
        end else if (d1_bside[0] || (d1_qb > ONE)) begin
            n_g_wb = ONE;
        end else begin
            n_g_wb = d1_qb;
        end
        n_g_s = (WW+1)'(n_g_wa) + (WW+1)'(n_g_wb);
    end

    // Clamped weights, then the products for the rescaling quotients.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_wa    <= n_g_wa;
            r_g_wb    <= n_g_wb;
            r_g_s     <= n_g_s;
            r_g_e     <= WW'(n_g_s - (WW+1)'(ONE));
            r_g_neg   <= n_g_s > (WW+1)'(ONE);
            r_g_degen <= d1_side[2];
            r_g_geom  <= d1_side[SW1-1:3];

            r_h_xa    <= r_g_wb * r_g_e;
            r_h_xb    <= r_g_wa * r_g_e;
            r_h_wa    <= r_g_wa;
            r_h_wb    <= r_g_wb;
            r_h_s     <= r_g_s;
            r_h_neg   <= r_g_neg;
            r_h_degen <= r_g_degen;
            r_h_geom  <= r_g_geom;
        end
    end

    ptcb_div #(.XW(XW2), .YW(WW+1), .QW(WW), .SW(SW2)) u_div_ra (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_h_v),
        .i_x(XW2'(r_h_xa)), .i_y(r_h_s),
        .i_side({r_h_geom, r_h_degen, r_h_neg, r_h_s, r_h_wa}),
        .o_valid(d2_v), .o_q(d2_qa), .o_side(d2_side)
    );
    ptcb_div #(.XW(XW2), .YW(WW+1), .QW(WW), .SW(WW)) u_div_rb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_h_v),
        .i_x(XW2'(r_h_xb)), .i_y(r_h_s),
        .i_side(r_h_wb),
        .o_valid(), .o_q(d2_qb), .o_side(d2_bside)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (d2_side[2*WW+1]) begin
                r_i_wa <= d2_side[WW-1:0] - d2_qa;
                r_i_wb <= d2_bside - d2_qb;
                r_i_wc <= '0;
            end else begin
                r_i_wa <= d2_side[WW-1:0];
                r_i_wb <= d2_bside;
                r_i_wc <= WW'((WW+1)'(ONE) - d2_side[2*WW:WW]);
            end
            r_i_degen <= d2_side[2*WW+2];
            r_i_geom  <= d2_side[SW2-1:2*WW+3];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            i_c[k]  = r_i_geom[k*CW +: CW];
            i_ea[k] = r_i_geom[3*CW + k*EW +: EW];
            i_eb[k] = r_i_geom[3*CW + 3*EW + k*EW +: EW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_j_pa[k] <= $signed({1'b0, r_i_wa}) * i_ea[k];
                r_j_pb[k] <= $signed({1'b0, r_i_wb}) * i_eb[k];
                r_j_c[k]  <= i_c[k];
            end
            r_j_wa    <= r_i_wa;
            r_j_wb    <= r_i_wb;
            r_j_wc    <= r_i_wc;
            r_j_degen <= r_i_degen;
        end
    end

    always_comb begin
        logic signed [NW-1:0] v_t;
        logic signed [NW-1:0] v_n;
        for (int k = 0; k < 3; k++) begin
            v_t = NW'(r_j_pa[k]) + NW'(r_j_pb[k]);
            v_n = NW'(r_j_c[k]) + (v_t >>> FB);
            if ((v_n[NW-1:CW-1] == '0) || (v_n[NW-1:CW-1] == '1)) begin
                n_near[k] = v_n[CW-1:0];
            end else if (v_n[NW-1]) begin
                n_near[k] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n_near[k] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_found <= !r_j_degen;
            r_o_wa    <= r_j_degen ? '0 : r_j_wa;
            r_o_wb    <= r_j_degen ? '0 : r_j_wb;
            r_o_wc    <= r_j_degen ? '0 : r_j_wc;
            for (int k = 0; k < 3; k++) begin
                r_o_near[k] <= r_j_degen ? '0 : n_near[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v     <= 1'b0;
            r_e_v     <= 1'b0;
            r_f_v     <= 1'b0;
            r_g_v     <= 1'b0;
            r_h_v     <= 1'b0;
            r_i_v     <= 1'b0;
            r_j_v     <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_d_v     <= m_v;
            r_e_v     <= r_d_v;
            r_f_v     <= r_e_v;
            r_g_v     <= d1_v;
            r_h_v     <= r_g_v;
            r_i_v     <= d2_v;
            r_j_v     <= r_i_v;
            r_o_valid <= r_j_v;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_found    = r_o_found;
    assign o_weight_a = r_o_wa;
    assign o_weight_b = r_o_wb;
    assign o_weight_c = r_o_wc;
    assign o_near_x   = r_o_near[0];
    assign o_near_y   = r_o_near[1];
    assign o_near_z   = r_o_near[2];

endmodule
